@@ design/vls_pkg.sv @@
// shared types and constants of the velocity limit step block
package vls_pkg;

	localparam int unsigned LIM_LAT  = 67;
	localparam int unsigned PIPE_LEN = 3 + LIM_LAT;

	localparam logic [65:0] ZERO_SPEED2 = 66'd4295;

	localparam logic [1:0] REG_MAX_ADD   = 2'd0;
	localparam logic [1:0] REG_MAX_DAMP  = 2'd1;
	localparam logic [1:0] REG_DAMP_GAIN = 2'd2;

	localparam logic [20:0] DAMP_GAIN_RST = 21'd65536;

	typedef logic [36:0] wmag_t;
	typedef logic [30:0] lmag_t;

	typedef struct packed {
		logic [2:0][31:0] vel;
		logic [2:0]       aneg;
	} side_t;

	typedef struct packed {
		logic [2:0][31:0] new_vel;
		logic [2:0][31:0] impulse;
	} result_t;

endpackage

@@ design/vls_limit.sv @@
// pipelined length limiter for one 3-d vector of magnitudes
module vls_limit (
	input  logic                 clk,
	input  logic                 en,
	input  vls_pkg::wmag_t [2:0] m,
	input  vls_pkg::lmag_t       maxv,
	output vls_pkg::lmag_t [2:0] q
);
	import vls_pkg::*;

	typedef struct packed {
		logic [63:0]      rad;
		logic [34:0]      rem;
		logic [31:0]      root;
		logic [2:0][61:0] p;
		logic [2:0][30:0] a;
		logic             over;
	} sqrt_t;

	typedef struct packed {
		logic [2:0][61:0] rem;
		logic [2:0][30:0] qt;
		logic [31:0]      d;
		logic [2:0][30:0] a;
		logic             over;
	} divst_t;

	function automatic sqrt_t sqrt_step(sqrt_t x);
		sqrt_t       y;
		logic [34:0] rs;
		logic [34:0] tr;
		y = x;
		rs = {x.rem[32:0], x.rad[63:62]};
		tr = {1'b0, x.root, 2'b01};
		y.rad = {x.rad[61:0], 2'b00};
		if (rs >= tr) begin
			y.rem = rs - tr;
			y.root = {x.root[30:0], 1'b1};
		end else begin
			y.rem = rs;
			y.root = {x.root[30:0], 1'b0};
		end
		return y;
	endfunction

	function automatic divst_t div_step(divst_t x, int unsigned bitn);
		divst_t      y;
		logic [62:0] dv;
		logic [62:0] rx;
		y = x;
		dv = 63'(x.d) << bitn;
		for (int i = 0; i < 3; i++) begin
			rx = {1'b0, x.rem[i]};
			if (rx >= dv) begin
				y.rem[i] = 62'(rx - dv);
				y.qt[i][bitn] = 1'b1;
			end
		end
		return y;
	endfunction

	// stage 1: bring all components below 2^31
	logic [36:0]      or_all;
	logic [2:0]       sh;
	logic [2:0][30:0] a_s1;
	logic             ovf_s1;

	always_comb begin
		or_all = m[0] | m[1] | m[2];
		if (or_all[36]) begin
			sh = 3'd6;
		end else if (or_all[35]) begin
			sh = 3'd5;
		end else if (or_all[34]) begin
			sh = 3'd4;
		end else if (or_all[33]) begin
			sh = 3'd3;
		end else if (or_all[32]) begin
			sh = 3'd2;
		end else if (or_all[31]) begin
			sh = 3'd1;
		end else begin
			sh = 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= 31'(m[i] >> sh);
			end
			ovf_s1 <= |or_all[36:31];
		end
	end

	// stage 2: squares and scaled numerators
	logic [2:0][61:0] sq_s2;
	logic [2:0][61:0] p_s2;
	logic [61:0]      mm_s2;
	logic [2:0][30:0] a_s2;
	logic             ovf_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 62'(a_s1[i]) * 62'(a_s1[i]);
				p_s2[i]  <= 62'(a_s1[i]) * 62'(maxv);
			end
			mm_s2  <= 62'(maxv) * 62'(maxv);
			a_s2   <= a_s1;
			ovf_s2 <= ovf_s1;
		end
	end

	// stage 3: squared length
	logic [63:0]      len2_s3;
	logic [61:0]      mm_s3;
	logic [2:0][61:0] p_s3;
	logic [2:0][30:0] a_s3;
	logic             ovf_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s3 <= 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);
			mm_s3   <= mm_s2;
			p_s3    <= p_s2;
			a_s3    <= a_s2;
			ovf_s3  <= ovf_s2;
		end
	end

	// square root, one result bit per stage
	sqrt_t sqrt_init;
	sqrt_t sqrt_s4 [32];

	always_comb begin
		sqrt_init.rad  = len2_s3;
		sqrt_init.rem  = '0;
		sqrt_init.root = '0;
		sqrt_init.p    = p_s3;
		sqrt_init.a    = a_s3;
		sqrt_init.over = ovf_s3 || (len2_s3 > {2'b00, mm_s3});
	end

	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					sqrt_s4[k] <= sqrt_step(sqrt_init);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					sqrt_s4[k] <= sqrt_step(sqrt_s4[k-1]);
				end
			end
		end
	end

	// division, one quotient bit per stage
	divst_t div_init;
	divst_t div_s5 [31];

	always_comb begin
		div_init.rem  = sqrt_s4[31].p;
		div_init.qt   = '0;
		div_init.d    = (sqrt_s4[31].root == 32'd0) ? 32'd1 : sqrt_s4[31].root;
		div_init.a    = sqrt_s4[31].a;
		div_init.over = sqrt_s4[31].over;
	end

	for (genvar j = 0; j < 31; j++) begin : g_div
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					div_s5[j] <= div_step(div_init, 30 - j);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					div_s5[j] <= div_step(div_s5[j-1], 30 - j);
				end
			end
		end
	end

	// result select
	logic [2:0][30:0] q_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!div_s5[30].over) begin
				q_s6 <= div_s5[30].a;
			end else if (maxv == '0) begin
				q_s6 <= '0;
			end else begin
				q_s6 <= div_s5[30].qt;
			end
		end
	end

	assign q = q_s6;

endmodule

@@ design/velocity_limit_step.sv @@
// velocity limit step: top level with pipeline, output buffer and registers
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: the
//   current velocity and position error in Q16.16, error scale in Q5.16.
//   Output channel (out_valid/out_ready) returns one result per item: new
//   velocity and limited impulse, in the order the items were taken.
//   Registers max_add_speed, max_damp_speed and damping_gain sit on the
//   APB port at byte addresses 0, 4 and 8; write them while no item is in
//   flight.
// Path: input stages for magnitudes, products and speed test, then the
//   32-stage square root and 31-stage divider inside each length limiter.
// Throughput: one item per cycle unless stalled; a valid bit per stage.
// Stall: a two-entry output buffer holds finished results; while it is
//   full the whole pipeline and in_ready hold, and nothing is lost.
// Reset: clears valid bits and the buffer, registers go to their defaults
//   (damping gain 1.0, both limits zero).
module velocity_limit_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic [31:0] err_x,
	input  logic [31:0] err_y,
	input  logic [31:0] err_z,
	input  logic [20:0] err_scale,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] new_vel_x,
	output logic [31:0] new_vel_y,
	output logic [31:0] new_vel_z,
	output logic [31:0] impulse_x,
	output logic [31:0] impulse_y,
	output logic [31:0] impulse_z,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vls_pkg::*;

	localparam logic [1:0] SKID_FULL = 2'd2;

	// configuration registers
	logic [30:0] max_add_q;
	logic [30:0] max_damp_q;
	logic [20:0] damp_gain_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_add_q   <= '0;
			max_damp_q  <= '0;
			damp_gain_q <= DAMP_GAIN_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MAX_ADD:   max_add_q   <= pwdata[30:0];
				REG_MAX_DAMP:  max_damp_q  <= pwdata[30:0];
				REG_DAMP_GAIN: damp_gain_q <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAX_ADD:   prdata = {1'b0, max_add_q};
			REG_MAX_DAMP:  prdata = {1'b0, max_damp_q};
			REG_DAMP_GAIN: prdata = {11'd0, damp_gain_q};
			default:       prdata = '0;
		endcase
	end

	// flow control
	logic [1:0]          cnt_q;
	logic                en;
	logic                push;
	logic                pop;
	logic [PIPE_LEN-1:0] vld_q;

	assign en        = (cnt_q != SKID_FULL);
	assign in_ready  = en;
	assign out_valid = (cnt_q != 2'd0);
	assign push      = en & vld_q[PIPE_LEN-1];
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LEN-2:0], in_valid};
		end
	end

	// stage 1: magnitudes
	logic [2:0][31:0] vin;
	logic [2:0][31:0] ein;
	logic [2:0][31:0] vmag_s1;
	logic [2:0][31:0] emag_s1;
	logic [2:0][31:0] vel_s1;
	logic [2:0]       aneg_s1;
	logic [20:0]      scale_s1;

	assign vin = {vel_z, vel_y, vel_x};
	assign ein = {err_z, err_y, err_x};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vmag_s1[i] <= vin[i][31] ? (32'd0 - vin[i]) : vin[i];
				emag_s1[i] <= ein[i][31] ? (32'd0 - ein[i]) : ein[i];
				aneg_s1[i] <= ein[i][31];
			end
			vel_s1   <= vin;
			scale_s1 <= err_scale;
		end
	end

	// stage 2: products
	logic [2:0][63:0] vsq_s2;
	logic [2:0][52:0] aprod_s2;
	logic [2:0][52:0] dprod_s2;
	logic [2:0][31:0] vel_s2;
	logic [2:0]       aneg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vsq_s2[i]   <= 64'(vmag_s1[i]) * 64'(vmag_s1[i]);
				aprod_s2[i] <= 53'(emag_s1[i]) * 53'(scale_s1);
				dprod_s2[i] <= 53'(vmag_s1[i]) * 53'(damp_gain_q);
			end
			vel_s2  <= vel_s1;
			aneg_s2 <= aneg_s1;
		end
	end

	// stage 3: small speed test
	logic [65:0]  speed2;
	logic         zero_v;
	wmag_t [2:0]  amag_s3;
	wmag_t [2:0]  dmag_s3;
	side_t        side_s3;

	assign speed2 = 66'(vsq_s2[0]) + 66'(vsq_s2[1]) + 66'(vsq_s2[2]);
	assign zero_v = (speed2 < ZERO_SPEED2);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				amag_s3[i] <= aprod_s2[i][52:16];
				dmag_s3[i] <= zero_v ? '0 : dprod_s2[i][52:16];
			end
			side_s3.vel  <= zero_v ? '0 : vel_s2;
			side_s3.aneg <= aneg_s2;
		end
	end

	// length limiters
	lmag_t [2:0] alim;
	lmag_t [2:0] dlim;

	vls_limit u_add_lim (
		.clk  (clk),
		.en   (en),
		.m    (amag_s3),
		.maxv (max_add_q),
		.q    (alim)
	);

	vls_limit u_damp_lim (
		.clk  (clk),
		.en   (en),
		.m    (dmag_s3),
		.maxv (max_damp_q),
		.q    (dlim)
	);

	// sideband delay matching the limiters
	side_t side_s4 [LIM_LAT];

	for (genvar k = 0; k < LIM_LAT; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					side_s4[k] <= side_s3;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					side_s4[k] <= side_s4[k-1];
				end
			end
		end
	end

	// combine and saturate
	result_t res_d;

	always_comb begin
		logic [34:0] aext;
		logic [34:0] dext;
		logic [34:0] av;
		logic [34:0] dv;
		logic [34:0] vv;
		logic [34:0] sum;
		logic [31:0] v;
		for (int i = 0; i < 3; i++) begin
			v    = side_s4[LIM_LAT-1].vel[i];
			aext = {4'd0, alim[i]};
			dext = {4'd0, dlim[i]};
			av   = side_s4[LIM_LAT-1].aneg[i] ? (35'd0 - aext) : aext;
			dv   = v[31] ? dext : (35'd0 - dext);
			vv   = {{3{v[31]}}, v};
			sum  = vv + av + dv;
			if (!sum[34] && (|sum[33:31])) begin
				res_d.new_vel[i] = 32'h7fff_ffff;
			end else if (sum[34] && !(&sum[33:31])) begin
				res_d.new_vel[i] = 32'h8000_0000;
			end else begin
				res_d.new_vel[i] = sum[31:0];
			end
			res_d.impulse[i] = av[31:0];
		end
	end

	// two-entry output buffer
	result_t slot0_q;
	result_t slot1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (pop && push) begin
			if (cnt_q == 2'd1) begin
				slot0_q <= res_d;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= res_d;
			end
		end else if (pop) begin
			slot0_q <= slot1_q;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= res_d;
			end else begin
				slot1_q <= res_d;
			end
		end
	end

	assign new_vel_x = slot0_q.new_vel[0];
	assign new_vel_y = slot0_q.new_vel[1];
	assign new_vel_z = slot0_q.new_vel[2];
	assign impulse_x = slot0_q.impulse[0];
	assign impulse_y = slot0_q.impulse[1];
	assign impulse_z = slot0_q.impulse[2];

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid)
		else $error("result transfer into buffer did not show on output");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == SKID_FULL && !out_ready) |=> !in_ready)
		else $error("input taken while output buffer full and stalled");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == 2'd1 && !push) |=> !out_valid)
		else $error("output valid after last result left");

endmodule

@@ tb/sv/tb_velocity_limit_step.sv @@
// testbench for velocity_limit_step: random and directed vectors checked against a predictor
`timescale 1ns / 100ps

module tb_velocity_limit_step;
	import vls_pkg::*;

	typedef struct {
		logic [31:0] nv[3];
		logic [31:0] imp[3];
	} step_res_t;

	class step_scoreboard;
		bit [30:0] max_add;
		bit [30:0] max_damp;
		bit [20:0] gain;
		step_res_t pending[$];
		int errors;

		function new();
			max_add = 0;
			max_damp = 0;
			gain = DAMP_GAIN_RST;
			errors = 0;
		endfunction

		function automatic logic [63:0] isqrt(logic [63:0] n);
			logic [63:0] r;
			logic [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function automatic void clamp_len(ref logic [63:0] m[3], input logic [63:0] mx);
			int sh;
			logic [63:0] a[3];
			logic [63:0] l2;
			logic [63:0] len;
			sh = 0;
			while (sh < 63 && ((m[0] >> sh) | (m[1] >> sh) | (m[2] >> sh)) > 64'h7fffffff)
				sh++;
			l2 = 0;
			for (int i = 0; i < 3; i++) begin
				a[i] = m[i] >> sh;
				l2 += a[i] * a[i];
			end
			if (sh == 0 && l2 <= mx * mx) return;
			if (mx == 0) begin
				for (int i = 0; i < 3; i++) m[i] = 0;
				return;
			end
			len = isqrt(l2);
			if (len == 0) len = 1;
			for (int i = 0; i < 3; i++) m[i] = (a[i] * mx) / len;
		endfunction

		function void note_input(logic [31:0] v[3], logic [31:0] e[3], logic [20:0] sc);
			logic [63:0] vm[3], am[3], dm[3];
			bit vn[3], an[3];
			logic [63:0] sp2;
			longint s, ai;
			step_res_t r;
			sp2 = 0;
			for (int i = 0; i < 3; i++) begin
				vn[i] = v[i][31];
				vm[i] = vn[i] ? (64'd1 << 32) - v[i] : {32'd0, v[i]};
				an[i] = e[i][31];
				am[i] = an[i] ? (64'd1 << 32) - e[i] : {32'd0, e[i]};
				sp2 += vm[i] * vm[i];
			end
			if (sp2 < 4295) begin
				for (int i = 0; i < 3; i++) begin
					vm[i] = 0;
					vn[i] = 0;
				end
			end
			for (int i = 0; i < 3; i++) begin
				am[i] = (am[i] * sc) >> 16;
				dm[i] = (vm[i] * gain) >> 16;
			end
			clamp_len(am, {33'd0, max_add});
			clamp_len(dm, {33'd0, max_damp});
			for (int i = 0; i < 3; i++) begin
				ai = an[i] ? -longint'(am[i]) : longint'(am[i]);
				s = (vn[i] ? -longint'(vm[i]) : longint'(vm[i])) + ai
					+ (vn[i] ? longint'(dm[i]) : -longint'(dm[i]));
				if (s > 64'sd2147483647) s = 64'sd2147483647;
				if (s < -64'sd2147483648) s = -64'sd2147483648;
				r.nv[i] = s[31:0];
				r.imp[i] = ai[31:0];
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] nv[3], logic [31:0] imp[3]);
			step_res_t x;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result", $time);
				errors++;
				return;
			end
			x = pending.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (nv[i] !== x.nv[i]) begin
					$display("%0t: new_vel[%0d] expected %h actual %h", $time, i, x.nv[i], nv[i]);
					errors++;
				end
				if (imp[i] !== x.imp[i]) begin
					$display("%0t: impulse[%0d] expected %h actual %h", $time, i, x.imp[i], imp[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [31:0] vel_x = 0, vel_y = 0, vel_z = 0, err_x = 0, err_y = 0, err_z = 0;
	logic [20:0] err_scale = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [31:0] new_vel_x, new_vel_y, new_vel_z, impulse_x, impulse_y, impulse_z;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;

	step_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycle_count = 0;

	velocity_limit_step i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic [31:0] nv[3], imp[3];
		if (arst_n && out_valid && out_ready) begin
			nv = '{new_vel_x, new_vel_y, new_vel_z};
			imp = '{impulse_x, impulse_y, impulse_z};
			sb.check_result(nv, imp);
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		case (idx)
			REG_MAX_ADD: sb.max_add = val[30:0];
			REG_MAX_DAMP: sb.max_damp = val[30:0];
			REG_DAMP_GAIN: sb.gain = val[20:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send_item(logic [31:0] v[3], logic [31:0] e[3], logic [20:0] sc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		vel_x <= v[0]; vel_y <= v[1]; vel_z <= v[2];
		err_x <= e[0]; err_y <= e[1]; err_z <= e[2];
		err_scale <= sc;
		do @(posedge clk); while (!in_ready);
		sb.note_input(v, e, sc);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(4095) - 2048;
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return {{12{$urandom_range(1) ? 1'b1 : 1'b0}}, 20'($urandom)};
		endcase
	endfunction

	function automatic logic [20:0] rand_scale();
		case ($urandom_range(3))
			0: return 21'($urandom_range(1048576));
			1: return $urandom_range(1) ? 21'd1048576 : 21'd0;
			2: return 21'($urandom);
			default: return 21'($urandom_range(131072));
		endcase
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LEN + 10) @(posedge clk);
	endtask

	task automatic random_phase(int n, int idle, int stall);
		logic [31:0] v[3], e[3];
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int k = 0; k < n; k++) begin
			foreach (v[i]) v[i] = rand_comp();
			foreach (e[i]) e[i] = rand_comp();
			send_item(v, e, rand_scale());
		end
		drain();
	endtask

	initial begin
		logic [31:0] v[3], e[3];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// reset defaults: both limits zero
		v = '{32'h00010000, 32'hffff0000, 32'd5};
		e = '{32'h00020000, 32'd0, 32'hfffe0000};
		send_item(v, e, 21'd65536);
		drain();

		write_reg(REG_MAX_ADD, 32'h0003_0000);
		write_reg(REG_MAX_DAMP, 32'h0002_0000);
		write_reg(REG_DAMP_GAIN, 32'h0000_8000);
		v = '{32'd40, 32'd30, 32'd0};
		send_item(v, e, 21'd65536);
		v = '{32'd0, 32'd0, 32'd0};
		send_item(v, e, 21'd0);
		v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
		e = '{32'h80000000, 32'h7fffffff, 32'h80000000};
		send_item(v, e, 21'd1048576);
		send_item(v, e, 21'h1fffff);
		v = '{32'h00030000, 32'd0, 32'd0};
		e = '{32'h00030000, 32'd0, 32'd0};
		send_item(v, e, 21'd65536);
		v = '{32'hffffffff, 32'hffffffff, 32'hffffffff};
		e = '{32'hffffffff, 32'h00000001, 32'hffffffff};
		send_item(v, e, 21'd1);
		drain();

		write_reg(REG_MAX_ADD, 32'hffff_ffff);
		write_reg(REG_MAX_DAMP, 32'h7fff_ffff);
		write_reg(REG_DAMP_GAIN, 32'h0010_0000);
		v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		e = '{32'h80000000, 32'h80000000, 32'h80000000};
		send_item(v, e, 21'd1048576);
		random_phase(150, 0, 0);

		write_reg(REG_MAX_ADD, 32'd0);
		write_reg(REG_MAX_DAMP, 32'd0);
		write_reg(REG_DAMP_GAIN, 32'hffff_ffff);
		random_phase(150, 72, 0);

		write_reg(REG_MAX_ADD, 32'h0100_0000);
		write_reg(REG_MAX_DAMP, 32'h0000_8000);
		write_reg(REG_DAMP_GAIN, 32'd0);
		random_phase(200, 0, 72);

		write_reg(REG_MAX_ADD, $urandom);
		write_reg(REG_MAX_DAMP, $urandom);
		write_reg(REG_DAMP_GAIN, $urandom_range(1048576));
		random_phase(200, 30, 30);

		write_reg(REG_MAX_ADD, 32'h0010_0000);
		write_reg(REG_MAX_DAMP, 32'h7fff_ffff);
		write_reg(REG_DAMP_GAIN, 32'h0001_0000);
		random_phase(200, 0, 0);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
design/vls_pkg.sv
design/vls_limit.sv
design/velocity_limit_step.sv
tb/sv/tb_velocity_limit_step.sv
